// ===== rtl/core/three_way_power_normalized_crossfader_defines.svh =====
// Assertion macros shared by the crossfader RTL.
`ifndef THREE_WAY_POWER_NORMALIZED_CROSSFADER_DEFINES_SVH
`define THREE_WAY_POWER_NORMALIZED_CROSSFADER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNXF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNXF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pnxf_pkg.sv =====
// Types, constants and the microcode program of the crossfader.
package pnxf_pkg;

   // Sample and gain formats.
   localparam int SAMPLE_BITS = 16;
   localparam int GAIN_W      = 17;
   localparam logic [GAIN_W-1:0] UNITY     = GAIN_W'(65536);
   localparam logic [GAIN_W-1:0] FADE_INIT = GAIN_W'(137);

   // Mode codes of the input item.
   localparam logic [1:0] MODE_DRY    = 2'd0;
   localparam logic [1:0] MODE_BYPASS = 2'd1;
   localparam logic [1:0] MODE_USER   = 2'd2;
   localparam logic [1:0] MODE_TARGET = 2'd3;

   // Shared multiplier and accumulator.
   localparam int MUL_W = GAIN_W + 1;
   localparam int ACC_W = 2 * MUL_W;

   // Power sum, square root and division widths.
   localparam int SUM_W     = 2 * GAIN_W;
   localparam int RAD_PAD   = 16;
   localparam int RAD_W     = SUM_W + RAD_PAD;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int REM_SQ_W  = ROOT_W + 1;
   localparam int ROOT_FRAC = 24;
   localparam int NUM_W     = GAIN_W + ROOT_FRAC;
   localparam logic [SUM_W-1:0] NORM_MIN = SUM_W'(4295);

   // Iteration counts of the bit-serial units.
   localparam int SQRT_ITERS = ROOT_W;
   localparam int DIV_ITERS  = GAIN_W;
   localparam int CNT_W      = $clog2(SQRT_ITERS);

   // Output rounding and saturation.
   localparam int MIX_SHIFT = 16;
   localparam int RND_W     = ACC_W - MIX_SHIFT;
   localparam logic signed [ACC_W-1:0] MIX_RND = ACC_W'(1 << (MIX_SHIFT - 1));
   localparam logic signed [RND_W-1:0] SAT_HI  = RND_W'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [RND_W-1:0] SAT_LO  = RND_W'(-(1 << (SAMPLE_BITS - 1)));

   // Program counter.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE  = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_ROOT  = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_DIV   = STEP_W'(7);
   localparam logic [STEP_W-1:0] STEP_MIX   = STEP_W'(8);
   localparam logic [STEP_W-1:0] STEP_EMIT  = STEP_W'(15);

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_MAC_SQ,
      OP_MAC_MIX,
      OP_CHECK,
      OP_ROOT,
      OP_DIV_INIT,
      OP_DIV,
      OP_STORE,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      SRC_DRY,
      SRC_USER,
      SRC_TARGET
   } src_type;

   typedef enum logic [2:0] {
      JMP_NEVER,
      JMP_NO_REQ,
      JMP_LOW_POWER,
      JMP_COUNT,
      JMP_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type            op;
      src_type           src;
      logic              chan;
      logic              first;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ucode_type;

   function automatic ucode_type uw(input op_type op, input src_type src, input logic chan,
                                    input logic first, input cond_type cond,
                                    input logic [STEP_W-1:0] target);
      ucode_type w;
      w.op     = op;
      w.src    = src;
      w.chan   = chan;
      w.first  = first;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // The program: one control word per step. The last step wraps to idle.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         STEP_W'(0):  w = uw(OP_IDLE,     SRC_DRY,    1'b0, 1'b0, JMP_NO_REQ,    STEP_IDLE);
         STEP_W'(1):  w = uw(OP_MAC_SQ,   SRC_DRY,    1'b0, 1'b1, JMP_NEVER,     STEP_IDLE);
         STEP_W'(2):  w = uw(OP_MAC_SQ,   SRC_USER,   1'b0, 1'b0, JMP_NEVER,     STEP_IDLE);
         STEP_W'(3):  w = uw(OP_MAC_SQ,   SRC_TARGET, 1'b0, 1'b0, JMP_NEVER,     STEP_IDLE);
         STEP_W'(4):  w = uw(OP_CHECK,    SRC_DRY,    1'b0, 1'b0, JMP_LOW_POWER, STEP_MIX);
         STEP_W'(5):  w = uw(OP_ROOT,     SRC_DRY,    1'b0, 1'b0, JMP_COUNT,     STEP_ROOT);
         STEP_W'(6):  w = uw(OP_DIV_INIT, SRC_DRY,    1'b0, 1'b0, JMP_NEVER,     STEP_IDLE);
         STEP_W'(7):  w = uw(OP_DIV,      SRC_DRY,    1'b0, 1'b0, JMP_COUNT,     STEP_DIV);
         STEP_W'(8):  w = uw(OP_MAC_MIX,  SRC_DRY,    1'b0, 1'b1, JMP_NEVER,     STEP_IDLE);
         STEP_W'(9):  w = uw(OP_MAC_MIX,  SRC_USER,   1'b0, 1'b0, JMP_NEVER,     STEP_IDLE);
         STEP_W'(10): w = uw(OP_MAC_MIX,  SRC_TARGET, 1'b0, 1'b0, JMP_NEVER,     STEP_IDLE);
         STEP_W'(11): w = uw(OP_STORE,    SRC_DRY,    1'b0, 1'b0, JMP_NEVER,     STEP_IDLE);
         STEP_W'(12): w = uw(OP_MAC_MIX,  SRC_DRY,    1'b1, 1'b1, JMP_NEVER,     STEP_IDLE);
         STEP_W'(13): w = uw(OP_MAC_MIX,  SRC_USER,   1'b1, 1'b0, JMP_NEVER,     STEP_IDLE);
         STEP_W'(14): w = uw(OP_MAC_MIX,  SRC_TARGET, 1'b1, 1'b0, JMP_NEVER,     STEP_IDLE);
         STEP_W'(15): w = uw(OP_EMIT,     SRC_DRY,    1'b0, 1'b0, JMP_OUT_BUSY,  STEP_EMIT);
         default:     w = uw(OP_IDLE,     SRC_DRY,    1'b0, 1'b0, JMP_NO_REQ,    STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/core/pnxf_req_if.sv =====
// Input channel of the crossfader: one stereo frame of three sources and a mode.
interface pnxf_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             mode;
   logic signed [pnxf_pkg::SAMPLE_BITS-1:0] dry_left;
   logic signed [pnxf_pkg::SAMPLE_BITS-1:0] dry_right;
   logic signed [pnxf_pkg::SAMPLE_BITS-1:0] user_left;
   logic signed [pnxf_pkg::SAMPLE_BITS-1:0] user_right;
   logic signed [pnxf_pkg::SAMPLE_BITS-1:0] target_left;
   logic signed [pnxf_pkg::SAMPLE_BITS-1:0] target_right;

   modport source (
      output valid, mode, dry_left, dry_right, user_left, user_right,
             target_left, target_right,
      input  ready
   );

   modport sink (
      input  valid, mode, dry_left, dry_right, user_left, user_right,
             target_left, target_right,
      output ready
   );
endinterface

// ===== rtl/core/pnxf_rsp_if.sv =====
// Result channel of the crossfader: one mixed stereo frame.
interface pnxf_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [pnxf_pkg::SAMPLE_BITS-1:0] out_left;
   logic signed [pnxf_pkg::SAMPLE_BITS-1:0] out_right;

   modport source (
      output valid, out_left, out_right,
      input  ready
   );

   modport sink (
      input  valid, out_left, out_right,
      output ready
   );
endinterface

// ===== rtl/core/three_way_power_normalized_crossfader.sv =====
// Top level of the three-way constant-power crossfader with gain slew.
//
// Each accepted item is a stereo frame from the dry, user wet and target wet
// sources plus a mode. The three gains slew toward the mode's targets by at most
// the configured fade step, are normalized to unit power, and weight the sources
// into one saturated stereo result. Control is a 16-step microcode program over a
// shared 18x18 multiplier, a bit-serial square root and three bit-serial
// dividers. The square root and the division, one result bit per cycle, set most
// of the time from acceptance to the next acceptance, and the shared multiplier
// adds its multiply-accumulate steps. When the total gain power is below the
// normalization threshold (all three gains close to zero, which slewing back and
// forth between modes can reach) the root and division are skipped. A finished
// result waits in an output register, so the next item is accepted while it is
// still unread; the program holds in its last step only if the previous result
// has not yet been taken.
`include "three_way_power_normalized_crossfader_defines.svh"

module three_way_power_normalized_crossfader (
   input  logic                             clock,
   input  logic                             reset,
   pnxf_req_if.sink                         req_chan,
   pnxf_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_en,
   input  logic [pnxf_pkg::GAIN_W-1:0]      csr_write_data
);

   localparam int SB  = pnxf_pkg::SAMPLE_BITS;
   localparam int GW  = pnxf_pkg::GAIN_W;
   localparam int RW  = pnxf_pkg::ROOT_W;

   // Control state.
   logic [pnxf_pkg::STEP_W-1:0] step_ff, step_in;
   logic [pnxf_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [GW-1:0]               fade_ff, fade_in;
   logic [GW-1:0]               gain_ff [3];
   logic [GW-1:0]               gain_in [3];

   // Datapath registers.
   logic signed [pnxf_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [pnxf_pkg::RAD_W-1:0]        rad_ff, rad_in;
   logic [pnxf_pkg::REM_SQ_W-1:0]     rem_sq_ff, rem_sq_in;
   logic [RW-1:0]                     root_ff, root_in;
   logic [RW-1:0]                     div_rem_ff [3];
   logic [RW-1:0]                     div_rem_in [3];
   logic [GW-1:0]                     q_ff [3];
   logic [GW-1:0]                     q_in [3];
   logic signed [SB-1:0]              smp_ff [3][2];
   logic signed [SB-1:0]              smp_in [3][2];
   logic signed [SB-1:0]              left_hold_ff, left_hold_in;
   logic signed [SB-1:0]              out_left_ff, out_left_in;
   logic signed [SB-1:0]              out_right_ff, out_right_in;

   // Decoded control word and helpers.
   pnxf_pkg::ucode_type               ctrl;
   logic                              taken;
   logic                              low_power;
   logic                              out_busy;
   logic [GW-1:0]                     gain_sel;
   logic [GW-1:0]                     q_sel;
   logic signed [SB-1:0]              smp_sel;
   logic signed [pnxf_pkg::MUL_W-1:0] mul_a;
   logic signed [pnxf_pkg::MUL_W-1:0] mul_b;
   logic signed [pnxf_pkg::ACC_W-1:0] prod;
   logic [GW-1:0]                     tgt [3];

   // Square root step.
   logic [pnxf_pkg::REM_SQ_W+1:0]     sq_cur;
   logic [pnxf_pkg::REM_SQ_W+1:0]     sq_trial;
   logic                              sq_ge;

   // Division lanes.
   logic [pnxf_pkg::NUM_W-1:0]        div_num [3];
   logic [RW:0]                       div_t [3];
   logic                              div_ge [3];
   logic [RW-1:0]                     div_rem_nx [3];

   // Move a gain toward its target by at most the fade step.
   function automatic logic [GW-1:0] slew_gain(input logic [GW-1:0] gain,
                                               input logic [GW-1:0] target,
                                               input logic [GW-1:0] step);
      logic [GW-1:0] d;
      logic [GW-1:0] res;
      if (target > gain) begin
         d   = target - gain;
         res = gain + ((d > step) ? step : d);
      end else begin
         d   = gain - target;
         res = gain - ((d > step) ? step : d);
      end
      return res;
   endfunction

   // Round the Q31 accumulator to the sample format and saturate.
   function automatic logic signed [SB-1:0] sat_sample(input logic signed [pnxf_pkg::ACC_W-1:0] a);
      logic signed [pnxf_pkg::ACC_W-1:0] b;
      logic signed [pnxf_pkg::RND_W-1:0] r;
      logic signed [SB-1:0]              res;
      b = a + pnxf_pkg::MIX_RND;
      r = b[pnxf_pkg::ACC_W-1:pnxf_pkg::MIX_SHIFT];
      if (r > pnxf_pkg::SAT_HI) begin
         res = SB'(pnxf_pkg::SAT_HI);
      end else if (r < pnxf_pkg::SAT_LO) begin
         res = SB'(pnxf_pkg::SAT_LO);
      end else begin
         res = SB'(r);
      end
      return res;
   endfunction

   assign ctrl = pnxf_pkg::ucode_rom(step_ff);

   // Handshake ports.
   assign req_chan.ready     = (ctrl.op == pnxf_pkg::OP_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_left  = out_left_ff;
   assign rsp_chan.out_right = out_right_ff;

   assign out_busy  = rsp_valid_ff && !rsp_chan.ready;
   assign low_power = (acc_ff[pnxf_pkg::SUM_W-1:0] < pnxf_pkg::NORM_MIN);

   // Gain targets of the incoming mode; bypass behaves as dry.
   always_comb begin
      tgt[0] = (req_chan.mode == pnxf_pkg::MODE_DRY || req_chan.mode == pnxf_pkg::MODE_BYPASS)
               ? pnxf_pkg::UNITY : '0;
      tgt[1] = (req_chan.mode == pnxf_pkg::MODE_USER) ? pnxf_pkg::UNITY : '0;
      tgt[2] = (req_chan.mode == pnxf_pkg::MODE_TARGET) ? pnxf_pkg::UNITY : '0;
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (ctrl.src)
         pnxf_pkg::SRC_DRY: begin
            gain_sel = gain_ff[0];
            q_sel    = q_ff[0];
            smp_sel  = smp_ff[0][ctrl.chan];
         end
         pnxf_pkg::SRC_USER: begin
            gain_sel = gain_ff[1];
            q_sel    = q_ff[1];
            smp_sel  = smp_ff[1][ctrl.chan];
         end
         pnxf_pkg::SRC_TARGET: begin
            gain_sel = gain_ff[2];
            q_sel    = q_ff[2];
            smp_sel  = smp_ff[2][ctrl.chan];
         end
         default: begin
            gain_sel = '0;
            q_sel    = '0;
            smp_sel  = '0;
         end
      endcase
   end

   always_comb begin
      unique case (ctrl.op)
         pnxf_pkg::OP_MAC_SQ: begin
            mul_a = {1'b0, gain_sel};
            mul_b = {1'b0, gain_sel};
         end
         pnxf_pkg::OP_MAC_MIX: begin
            mul_a = {{(pnxf_pkg::MUL_W - SB){smp_sel[SB-1]}}, smp_sel};
            mul_b = {1'b0, q_sel};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // One bit of the square root: bring in two radicand bits, try the subtract.
   assign sq_cur   = {rem_sq_ff, rad_ff[pnxf_pkg::RAD_W-1 -: 2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = (sq_cur >= sq_trial);

   // One quotient bit in each of the three division lanes.
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         div_num[l]    = {gain_ff[l], pnxf_pkg::ROOT_FRAC'(0)}
                         + pnxf_pkg::NUM_W'(root_ff >> 1);
         div_t[l]      = {div_rem_ff[l], q_ff[l][GW-1]};
         div_ge[l]     = (div_t[l] >= {1'b0, root_ff});
         div_rem_nx[l] = div_ge[l] ? RW'(div_t[l] - {1'b0, root_ff}) : div_t[l][RW-1:0];
      end
   end

   // Jump decision of the current step.
   always_comb begin
      unique case (ctrl.cond)
         pnxf_pkg::JMP_NEVER:     taken = 1'b0;
         pnxf_pkg::JMP_NO_REQ:    taken = !req_chan.valid;
         pnxf_pkg::JMP_LOW_POWER: taken = low_power;
         pnxf_pkg::JMP_COUNT:     taken = (cnt_ff != '0);
         pnxf_pkg::JMP_OUT_BUSY:  taken = out_busy;
         default:                 taken = 1'b0;
      endcase
   end

   // Next values of all registers, driven by the control word.
   always_comb begin
      step_in      = taken ? ctrl.target : step_ff + pnxf_pkg::STEP_W'(1);
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      fade_in      = fade_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      rem_sq_in    = rem_sq_ff;
      root_in      = root_ff;
      left_hold_in = left_hold_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      for (int l = 0; l < 3; l++) begin
         gain_in[l]    = gain_ff[l];
         div_rem_in[l] = div_rem_ff[l];
         q_in[l]       = q_ff[l];
         for (int c = 0; c < 2; c++) begin
            smp_in[l][c] = smp_ff[l][c];
         end
      end

      // Configuration write.
      if (csr_write_en) begin
         fade_in = csr_write_data;
      end

      // The result register empties when the item is taken.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (ctrl.op) inside
         pnxf_pkg::OP_IDLE: begin
            if (req_chan.valid) begin
               for (int l = 0; l < 3; l++) begin
                  gain_in[l] = slew_gain(gain_ff[l], tgt[l], fade_ff);
               end
               smp_in[0][0] = req_chan.dry_left;
               smp_in[0][1] = req_chan.dry_right;
               smp_in[1][0] = req_chan.user_left;
               smp_in[1][1] = req_chan.user_right;
               smp_in[2][0] = req_chan.target_left;
               smp_in[2][1] = req_chan.target_right;
            end
         end
         pnxf_pkg::OP_MAC_SQ, pnxf_pkg::OP_MAC_MIX: begin
            acc_in = ctrl.first ? prod : acc_ff + prod;
         end
         pnxf_pkg::OP_CHECK: begin
            rad_in    = {acc_ff[pnxf_pkg::SUM_W-1:0], pnxf_pkg::RAD_PAD'(0)};
            rem_sq_in = '0;
            root_in   = '0;
            cnt_in    = pnxf_pkg::CNT_W'(pnxf_pkg::SQRT_ITERS - 1);
            // Tiny power: the normalization factor is one.
            if (low_power) begin
               for (int l = 0; l < 3; l++) begin
                  q_in[l] = gain_ff[l];
               end
            end
         end
         pnxf_pkg::OP_ROOT: begin
            rad_in    = rad_ff << 2;
            rem_sq_in = sq_ge ? pnxf_pkg::REM_SQ_W'(sq_cur - sq_trial)
                              : sq_cur[pnxf_pkg::REM_SQ_W-1:0];
            root_in   = {root_ff[RW-2:0], sq_ge};
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - pnxf_pkg::CNT_W'(1);
            end
         end
         pnxf_pkg::OP_DIV_INIT: begin
            for (int l = 0; l < 3; l++) begin
               div_rem_in[l] = {1'b0, div_num[l][pnxf_pkg::NUM_W-1:GW]};
               q_in[l]       = div_num[l][GW-1:0];
            end
            cnt_in = pnxf_pkg::CNT_W'(pnxf_pkg::DIV_ITERS - 1);
         end
         pnxf_pkg::OP_DIV: begin
            for (int l = 0; l < 3; l++) begin
               div_rem_in[l] = div_rem_nx[l];
               q_in[l]       = {q_ff[l][GW-2:0], div_ge[l]};
            end
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - pnxf_pkg::CNT_W'(1);
            end
         end
         pnxf_pkg::OP_STORE: begin
            left_hold_in = sat_sample(acc_ff);
         end
         pnxf_pkg::OP_EMIT: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               out_left_in  = left_hold_ff;
               out_right_in = sat_sample(acc_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= pnxf_pkg::STEP_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fade_ff      <= pnxf_pkg::FADE_INIT;
         gain_ff[0]   <= pnxf_pkg::UNITY;
         gain_ff[1]   <= '0;
         gain_ff[2]   <= '0;
      end else begin
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         fade_ff      <= fade_in;
         for (int l = 0; l < 3; l++) begin
            gain_ff[l] <= gain_in[l];
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      rad_ff       <= rad_in;
      rem_sq_ff    <= rem_sq_in;
      root_ff      <= root_in;
      left_hold_ff <= left_hold_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      for (int l = 0; l < 3; l++) begin
         div_rem_ff[l] <= div_rem_in[l];
         q_ff[l]       <= q_in[l];
         for (int c = 0; c < 2; c++) begin
            smp_ff[l][c] <= smp_in[l][c];
         end
      end
   end

   // Checks on the sequencer and the gain arithmetic.
   `PNXF_ASSERT_NEXT(a_accept_starts_program, clock, reset,
                     req_chan.valid && req_chan.ready, step_ff == pnxf_pkg::STEP_FIRST,
                     "accepted item did not start the program")
   `PNXF_ASSERT_SAME(a_gain_in_range, clock, reset, 1'b1,
                     gain_ff[0] <= pnxf_pkg::UNITY && gain_ff[1] <= pnxf_pkg::UNITY
                     && gain_ff[2] <= pnxf_pkg::UNITY,
                     "kept gain above unity")
   `PNXF_ASSERT_SAME(a_norm_gain_in_range, clock, reset, ctrl.op == pnxf_pkg::OP_MAC_MIX,
                     q_ff[0] <= pnxf_pkg::UNITY && q_ff[1] <= pnxf_pkg::UNITY
                     && q_ff[2] <= pnxf_pkg::UNITY,
                     "normalized gain above unity")
   `PNXF_ASSERT_SAME(a_result_from_emit, clock, reset, $rose(rsp_valid_ff),
                     $past(ctrl.op == pnxf_pkg::OP_EMIT),
                     "result appeared outside the emit step")

endmodule

// ===== tb/sv/tb_three_way_power_normalized_crossfader.sv =====
// Self-checking testbench for the three-way crossfader: gain slew, power normalization and mixing.
module tb_three_way_power_normalized_crossfader;
   import pnxf_pkg::*;

   localparam int          SW          = SAMPLE_BITS;
   localparam longint      SAMPLE_MAX  = 2 ** (SW - 1) - 1;
   localparam longint      SAMPLE_MIN  = -(2 ** (SW - 1));
   localparam int          LONG_HOLD   = 600;
   localparam int unsigned STALL_LIMIT = 3000;
   localparam int          END_WAIT    = 100;
   localparam logic [GAIN_W-1:0] GAIN_ZERO = '0;
   localparam logic [GAIN_W-1:0] STEP_MAX  = '1;

   typedef struct {
      logic [1:0]           mode;
      logic signed [SW-1:0] dry_l;
      logic signed [SW-1:0] dry_r;
      logic signed [SW-1:0] user_l;
      logic signed [SW-1:0] user_r;
      logic signed [SW-1:0] tgt_l;
      logic signed [SW-1:0] tgt_r;
   } frame_type;

   typedef struct {
      logic signed [SW-1:0] left;
      logic signed [SW-1:0] right;
   } stereo_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en;
   logic [GAIN_W-1:0] csr_write_data;

   pnxf_req_if req_bus ();
   pnxf_rsp_if rsp_bus ();

   three_way_power_normalized_crossfader u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus),
      .rsp_chan       (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // Predicted block state: fade step and the three kept gains.
   logic [GAIN_W-1:0] slew_limit = FADE_INIT;
   logic [GAIN_W-1:0] lvl_dry    = UNITY;
   logic [GAIN_W-1:0] lvl_user   = GAIN_ZERO;
   logic [GAIN_W-1:0] lvl_target = GAIN_ZERO;

   stereo_type expected_mix[$];

   bit idle_on           = 1'b1;
   bit long_hold_pending = 1'b0;
   bit offering          = 1'b0;
   int frames_sent       = 0;
   int results_checked   = 0;
   int mismatches        = 0;
   int tiny_power_frames = 0;
   int steps_written     = 0;

   // Move one gain toward its goal by at most the fade step.
   function automatic logic [GAIN_W-1:0] step_toward(input logic [GAIN_W-1:0] lvl,
                                                     input logic [GAIN_W-1:0] goal);
      logic [GAIN_W-1:0] gap;
      if (goal > lvl) begin
         gap = goal - lvl;
         return lvl + ((gap > slew_limit) ? slew_limit : gap);
      end
      gap = lvl - goal;
      return lvl - ((gap > slew_limit) ? slew_limit : gap);
   endfunction

   // Integer square root, built one result bit at a time from the top.
   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned r;
      longint unsigned trial;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= v) r = trial;
      end
      return r;
   endfunction

   // Gain divided by the Q24 root, rounded half up, in Q16.
   function automatic longint unsigned scale_gain(input logic [GAIN_W-1:0] lvl,
                                                  input longint unsigned root);
      return ((64'(lvl) << 24) + (root >> 1)) / root;
   endfunction

   // Weighted sum of one channel, rounded and saturated.
   function automatic logic signed [SW-1:0] mix_channel(input logic signed [SW-1:0] d,
                                                        input logic signed [SW-1:0] u,
                                                        input logic signed [SW-1:0] t,
                                                        input longint gd, input longint gu,
                                                        input longint gt);
      longint acc;
      longint r;
      acc = longint'(d) * gd + longint'(u) * gu + longint'(t) * gt;
      r = (acc + 32768) >>> 16;
      if (r > SAMPLE_MAX) r = SAMPLE_MAX;
      else if (r < SAMPLE_MIN) r = SAMPLE_MIN;
      return r[SW-1:0];
   endfunction

   // Advance the predicted gains by one frame and return the expected mix.
   function automatic stereo_type crossfade_frame(input frame_type f);
      longint unsigned power;
      longint unsigned root;
      longint gd;
      longint gu;
      longint gt;
      stereo_type o;
      lvl_dry    = step_toward(lvl_dry,
                               (f.mode == MODE_DRY || f.mode == MODE_BYPASS) ? UNITY : GAIN_ZERO);
      lvl_user   = step_toward(lvl_user, (f.mode == MODE_USER) ? UNITY : GAIN_ZERO);
      lvl_target = step_toward(lvl_target, (f.mode == MODE_TARGET) ? UNITY : GAIN_ZERO);
      power = 64'(lvl_dry) * 64'(lvl_dry) + 64'(lvl_user) * 64'(lvl_user)
            + 64'(lvl_target) * 64'(lvl_target);
      if (power >= 64'(NORM_MIN)) begin
         root = floor_root(power << 16);
         gd = scale_gain(lvl_dry, root);
         gu = scale_gain(lvl_user, root);
         gt = scale_gain(lvl_target, root);
      end else begin
         // Too little power to normalize: the gains pass through unscaled.
         gd = longint'(lvl_dry);
         gu = longint'(lvl_user);
         gt = longint'(lvl_target);
         tiny_power_frames++;
      end
      o.left  = mix_channel(f.dry_l, f.user_l, f.tgt_l, gd, gu, gt);
      o.right = mix_channel(f.dry_r, f.user_r, f.tgt_r, gd, gu, gt);
      return o;
   endfunction

   // Random sample, biased toward the extremes and zero.
   function automatic logic signed [SW-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return SAMPLE_MIN[SW-1:0];
         1: return SAMPLE_MAX[SW-1:0];
         2: return '0;
         default: return SW'($urandom);
      endcase
   endfunction

   function automatic frame_type make_frame(input logic [1:0] mode, input longint dl,
                                            input longint dr, input longint ul,
                                            input longint ur, input longint tl,
                                            input longint tr);
      frame_type f;
      f.mode   = mode;
      f.dry_l  = dl[SW-1:0];
      f.dry_r  = dr[SW-1:0];
      f.user_l = ul[SW-1:0];
      f.user_r = ur[SW-1:0];
      f.tgt_l  = tl[SW-1:0];
      f.tgt_r  = tr[SW-1:0];
      return f;
   endfunction

   function automatic frame_type random_frame(input logic [1:0] mode);
      return make_frame(mode, pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                        pick_sample(), pick_sample());
   endfunction

   function automatic logic [1:0] mode_of(input src_type s);
      case (s)
         SRC_USER:   return MODE_USER;
         SRC_TARGET: return MODE_TARGET;
         default:    return MODE_DRY;
      endcase
   endfunction

   function automatic src_type next_source(input src_type s);
      case (s)
         SRC_DRY:  return SRC_USER;
         SRC_USER: return SRC_TARGET;
         default:  return SRC_DRY;
      endcase
   endfunction

   // Offer one item, with an occasional gap first, and record its expected mix.
   task automatic send_frame(input frame_type f);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         if (offering) begin
            req_bus.valid <= 1'b0;
            offering = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      offering             = 1'b1;
      req_bus.mode         <= f.mode;
      req_bus.dry_left     <= f.dry_l;
      req_bus.dry_right    <= f.dry_r;
      req_bus.user_left    <= f.user_l;
      req_bus.user_right   <= f.user_r;
      req_bus.target_left  <= f.tgt_l;
      req_bus.target_right <= f.tgt_r;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_mix.push_back(crossfade_frame(f));
      frames_sent++;
   endtask

   // Stop offering and wait until every expected mix has come back.
   task automatic finish_phase();
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
      end
      while (expected_mix.size() != 0) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_fade_step(input logic [GAIN_W-1:0] value);
      csr_write_data <= value;
      csr_write_en   <= 1'b1;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      slew_limit = value;
      steps_written++;
   endtask

   // Every mode with full-scale samples, at the reset fade step and above unity.
   task automatic test_mode_extremes();
      send_frame(make_frame(MODE_DRY, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                            SAMPLE_MAX, SAMPLE_MAX));
      send_frame(make_frame(MODE_BYPASS, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX,
                            SAMPLE_MAX, SAMPLE_MAX));
      finish_phase();
      write_fade_step(STEP_MAX);
      send_frame(make_frame(MODE_USER, 0, -1, SAMPLE_MAX, SAMPLE_MIN, 1, 0));
      send_frame(make_frame(MODE_TARGET, SAMPLE_MAX, SAMPLE_MIN, -1, 1, SAMPLE_MIN,
                            SAMPLE_MAX));
      send_frame(make_frame(MODE_BYPASS, SAMPLE_MAX, SAMPLE_MIN, 0, 0, 0, 0));
      send_frame(make_frame(MODE_USER, 0, 0, 0, 0, 0, 0));
      send_frame(make_frame(MODE_DRY, -1, 1, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX,
                            SAMPLE_MIN));
   endtask

   // Halve the single live gain once per setting until total power falls below the
   // normalization threshold, then freeze the gains there with a zero fade step.
   task automatic test_power_collapse();
      src_type holder;
      src_type mid;
      holder = SRC_DRY;
      for (int k = 15; k >= 6; k--) begin
         finish_phase();
         write_fade_step(GAIN_W'(1) << k);
         mid = next_source(holder);
         holder = next_source(mid);
         case (k % 3)
            0: begin
               send_frame(make_frame(mode_of(mid), SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                                     SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
               send_frame(make_frame(mode_of(holder), SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
                                     SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN));
            end
            default: begin
               send_frame(random_frame(mode_of(mid)));
               send_frame(random_frame(mode_of(holder)));
            end
         endcase
      end
      finish_phase();
      write_fade_step(GAIN_ZERO);
      send_frame(make_frame(MODE_DRY, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
                            SAMPLE_MAX, SAMPLE_MIN));
      send_frame(random_frame(MODE_TARGET));
   endtask

   // Random frames in mode runs, short and long, at one fade step setting.
   task automatic test_random_fades(input int count, input logic [GAIN_W-1:0] step);
      logic [1:0] mode;
      int run_left;
      finish_phase();
      write_fade_step(step);
      mode = MODE_DRY;
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            mode = 2'($urandom_range(0, 3));
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 250)
                                                    : $urandom_range(1, 10);
         end
         run_left--;
         send_frame(random_frame(mode));
      end
   endtask

   // Hold the result side off for a long stretch while items keep coming.
   task automatic test_output_backpressure();
      long_hold_pending = 1'b1;
      for (int i = 0; i < 12; i++) send_frame(random_frame(2'($urandom_range(0, 3))));
      finish_phase();
   endtask

   // Result side: ready with random stalls, plus the long hold on request.
   initial begin : result_sink
      int pause;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            pause = $urandom_range(1, 6);
            rsp_bus.ready <= 1'b0;
            repeat (pause) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic report_mismatch(input string what, input logic signed [SW-1:0] want,
                                  input logic signed [SW-1:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("MISMATCH result %0d %s: expected %0d, got %0d", results_checked, what,
                  want, got);
   endtask

   // Compare each accepted result with the oldest expected mix.
   always @(posedge clock) begin
      stereo_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_checked++;
         if (expected_mix.size() == 0) begin
            report_mismatch("unexpected result, out_left", '0, rsp_bus.out_left);
         end else begin
            want = expected_mix.pop_front();
            if (rsp_bus.out_left !== want.left)
               report_mismatch("out_left", want.left, rsp_bus.out_left);
            if (rsp_bus.out_right !== want.right)
               report_mismatch("out_right", want.right, rsp_bus.out_right);
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no item moved for %0d cycles, %0d results outstanding.",
               STALL_LIMIT, expected_mix.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Test sequence.
   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.mode         <= MODE_DRY;
      req_bus.dry_left     <= '0;
      req_bus.dry_right    <= '0;
      req_bus.user_left    <= '0;
      req_bus.user_right   <= '0;
      req_bus.target_left  <= '0;
      req_bus.target_right <= '0;
      csr_write_en         <= 1'b0;
      csr_write_data       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_mode_extremes();
      test_power_collapse();
      test_random_fades(220, GAIN_W'(1));
      test_random_fades(220, FADE_INIT);
      test_output_backpressure();
      test_random_fades(200, UNITY);
      test_random_fades(200, STEP_MAX);
      test_random_fades(160, GAIN_ZERO);
      test_random_fades(220, GAIN_W'(2048));
      test_random_fades(220, GAIN_W'($urandom_range(1, 65536)));
      test_random_fades(180, GAIN_W'($urandom_range(65537, 131071)));
      finish_phase();
      idle_on = 1'b0;
      test_random_fades(300, GAIN_W'($urandom_range(2, 300)));
      finish_phase();
      repeat (END_WAIT) @(posedge clock);

      $display("Sent %0d frames across %0d fade step settings, all modes, full-scale samples;",
               frames_sent, steps_written);
      $display("%0d frames fell below the normalization threshold; %0d results checked.",
               tiny_power_frames, results_checked);
      if (mismatches == 0 && expected_mix.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d results missing.", mismatches, expected_mix.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/pnxf_pkg.sv
rtl/core/pnxf_req_if.sv
rtl/core/pnxf_rsp_if.sv
rtl/core/three_way_power_normalized_crossfader.sv
tb/sv/tb_three_way_power_normalized_crossfader.sv
